// ----- rtl/filament_glow_column_renderer_core_assert.svh -----
// assertion macros shared by the renderer rtl
`ifndef FILAMENT_GLOW_COLUMN_RENDERER_CORE_ASSERT_SVH
`define FILAMENT_GLOW_COLUMN_RENDERER_CORE_ASSERT_SVH

// same-cycle implication under the async reset
`define FGCR_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication under the async reset
`define FGCR_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/fgcr_pkg.sv -----
// shared types, constants and tables of the filament glow renderer
`default_nettype none
package fgcr_pkg;

	localparam int NUM_TUBES = 8;
	localparam int NUM_ROWS  = 16;

	// field widths
	localparam int TUBE_W   = 3;
	localparam int ENERGY_W = 16;
	localparam int TIME_W   = 32;
	localparam int ROW_W    = 4;
	localparam int CH_W     = 8;
	localparam int IN_TDATA_W  = 56;
	localparam int OUT_TDATA_W = 32;

	localparam int TIDX_W    = (NUM_TUBES > 1) ? $clog2(NUM_TUBES) : 1;
	localparam int ROW_CNT_W = $clog2(NUM_ROWS);

	// configuration port
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;
	localparam logic [CFG_IDX_W-1:0] CFG_ATTACK_GAIN   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_COOLING_STEP  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_FLICKER_RATE  = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_FLICKER_DEPTH = 2'd3;

	// shared multiplier operands and product
	localparam int MUL_W  = 17;
	localparam int PROD_W = 2 * MUL_W;

	typedef struct packed {
		logic             en;
		logic [MUL_W-1:0] a;
		logic [MUL_W-1:0] b;
	} mul_req_t;

	typedef struct packed {
		logic              en;
		logic [TIDX_W-1:0] idx;
		logic [15:0]       data;
	} tmp_wr_t;

	// glow profile, one Q16 gain per row
	typedef logic [NUM_ROWS-1:0][16:0] glow_tab_t;

	function automatic glow_tab_t make_glow();
		glow_tab_t tab;
		int ad;
		tab = '0;
		for (int y = 0; y < NUM_ROWS; y++) begin
			ad = 2 * y - NUM_ROWS;
			if (ad < 0) begin
				ad = -ad;
			end
			tab[y] = 17'(65536 - (45875 * ad) / NUM_ROWS);
		end
		return tab;
	endfunction

	localparam glow_tab_t GLOW_TAB = make_glow();

	// quarter-wave sine, Q0.15, 17 points
	function automatic logic [14:0] qsine(input logic [4:0] idx);
		logic [14:0] s;
		unique case (idx)
			5'd0:    s = 15'd0;
			5'd1:    s = 15'd3212;
			5'd2:    s = 15'd6393;
			5'd3:    s = 15'd9512;
			5'd4:    s = 15'd12539;
			5'd5:    s = 15'd15446;
			5'd6:    s = 15'd18204;
			5'd7:    s = 15'd20787;
			5'd8:    s = 15'd23170;
			5'd9:    s = 15'd25329;
			5'd10:   s = 15'd27245;
			5'd11:   s = 15'd28898;
			5'd12:   s = 15'd30273;
			5'd13:   s = 15'd31356;
			5'd14:   s = 15'd32137;
			5'd15:   s = 15'd32609;
			default: s = 15'd32767;
		endcase
		return s;
	endfunction

endpackage
`default_nettype wire

// ----- rtl/fgcr_mul.sv -----
// shared 17x17 unsigned multiplier with registered product
`default_nettype none
module fgcr_mul (
	input  wire logic                     clk,
	input  wire fgcr_pkg::mul_req_t       req,
	output logic [fgcr_pkg::PROD_W-1:0]   prod
);
	import fgcr_pkg::*;

	logic [PROD_W-1:0] prod_q;

	// product holds while no new operation is issued
	always_ff @(posedge clk) begin
		if (req.en) begin
			prod_q <= PROD_W'(req.a) * PROD_W'(req.b);
		end
	end

	assign prod = prod_q;

endmodule
`default_nettype wire

// ----- rtl/fgcr_tstore.sv -----
// per-tube temperature register file
`default_nettype none
module fgcr_tstore (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire fgcr_pkg::tmp_wr_t            wr,
	input  wire logic [fgcr_pkg::TIDX_W-1:0]  rd_idx,
	output logic [15:0]                       rd_data
);
	import fgcr_pkg::*;

	logic [15:0] temp_q [NUM_TUBES];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_TUBES; i++) begin
				temp_q[i] <= '0;
			end
		end else if (wr.en) begin
			temp_q[wr.idx] <= wr.data;
		end
	end

	assign rd_data = temp_q[rd_idx];

endmodule
`default_nettype wire

// ----- rtl/filament_glow_column_renderer_core.sv -----
// filament glow column renderer: sequencer, registers and output stage
//
// Each input transfer updates the temperature of one tube and then renders
// that tube as NUM_ROWS pixels, row 0 first, the final row marked by tlast.
// The temperature, gradient, flicker, brightness and pixel products run
// through one shared 17x17 multiplier, at most one product per cycle, under
// the sequencer below. From its transfer to the next s_tready an item goes
// through the temperature, gradient, flicker and brightness work (with an
// extra product wait on the heating path and on the hot gradient segment),
// then per row the glow product, scale, three channel products and output
// load. The next item transfers in the idle state that follows; a stalled
// output holds the output load until the pixel can be taken.
// s_tready is high only while idle. A tube index at or above NUM_TUBES is
// taken and dropped without any pixel. Configuration writes land at once
// and should only be made while idle.
`default_nettype none
`include "filament_glow_column_renderer_core_assert.svh"
module filament_glow_column_renderer_core (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	// configuration writes
	input  wire logic                                cfg_we,
	input  wire logic [fgcr_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  wire logic [fgcr_pkg::CFG_DATA_W-1:0]     cfg_data,
	// input stream
	input  wire logic                                s_tvalid,
	output logic                                     s_tready,
	input  wire logic [fgcr_pkg::IN_TDATA_W-1:0]     s_tdata,  // tube[2:0] energy[18:3] time_ms[50:19]
	// pixel stream
	output logic                                     m_tvalid,
	input  wire logic                                m_tready,
	output logic [fgcr_pkg::OUT_TDATA_W-1:0]         m_tdata,  // column[2:0] row[6:3] red[14:7] green[22:15] blue[30:23]
	output logic                                     m_tlast   // final row of the column
);
	import fgcr_pkg::*;

	localparam logic [15:0] T_THRESH   = 16'd26214;  // 0.4
	localparam logic [15:0] TUBE_PHASE = 16'd7301;   // 0.7 rad
	localparam logic [15:0] B_BASE     = 16'd9830;   // 0.15
	localparam logic [MUL_W-1:0] K_COLD     = 17'd1275;
	localparam logic [MUL_W-1:0] K_HOT      = 17'd4233;
	localparam logic [MUL_W-1:0] K_RECIP10  = 17'd6554;  // 65536/10, rounded up
	localparam logic [MUL_W-1:0] K_BRIGHT   = 17'd55706; // 0.85
	localparam logic [16:0] ONE_Q16 = 17'd65536;
	localparam logic [ROW_CNT_W-1:0] LAST_ROW = ROW_CNT_W'(NUM_ROWS - 1);

	// gradient endpoints
	localparam logic [7:0] COLD_R = 8'd30,  COLD_G = 8'd0,   COLD_B = 8'd0;
	localparam logic [7:0] WARM_R = 8'd255, WARM_G = 8'd80,  WARM_B = 8'd0;
	localparam logic [7:0] HOT_R  = 8'd255, HOT_G  = 8'd255, HOT_B  = 8'd255;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_ATT,
		ST_ATT_W,
		ST_GRAD,
		ST_GRAD_W,
		ST_DIV_W,
		ST_PHASE,
		ST_PHASE_W,
		ST_SINE,
		ST_SINE_W,
		ST_DEPTH_W,
		ST_BRT_W,
		ST_BF_W,
		ST_ROW,
		ST_ROW_K,
		ST_CH0,
		ST_CH1,
		ST_CH2,
		ST_EMIT
	} state_t;

	// (x*256 + y + y*a - x*a) >> 8, endpoints come out exact
	function automatic logic [7:0] mix_ch(input logic [7:0] x, input logic [7:0] y,
			input logic [7:0] a);
		logic [17:0] acc;
		acc = {2'b00, x, 8'd0} + 18'(y) + 18'(y) * 18'(a) - 18'(x) * 18'(a);
		return acc[15:8];
	endfunction

	state_t state_q;

	// configuration registers
	logic [15:0] attack_gain_q;
	logic [15:0] cooling_step_q;
	logic [7:0]  flicker_rate_q;
	logic [15:0] flicker_depth_q;

	// current item
	logic [TUBE_W-1:0]   tube_q;
	logic [ENERGY_W-1:0] energy_q;
	logic [15:0]         time_lo_q;   // only the low bits reach the phase

	// working registers
	logic [15:0]          t_q;
	logic                 hot_q;
	logic [7:0]           a_q;
	logic [7:0]           rgb_q [3];
	logic [15:0]          phase_q;
	logic [14:0]          lo_q;
	logic                 top_q;
	logic                 neg_q;
	logic [16:0]          f_q;
	logic [16:0]          bf_q;
	logic [ROW_CNT_W-1:0] row_q;
	logic [7:0]           k_q;
	logic [7:0]           red_q;
	logic [7:0]           green_q;

	logic [PROD_W-1:0] prod;
	mul_req_t          mreq;
	tmp_wr_t           twr;
	logic [15:0]       t_rd;

	// input field views
	logic [TUBE_W-1:0]   in_tube;
	logic [ENERGY_W-1:0] in_energy;
	logic [TIME_W-1:0]   in_time;
	logic                in_ok;
	logic                in_xfer;

	assign in_tube   = s_tdata[2:0];
	assign in_energy = s_tdata[18:3];
	assign in_time   = s_tdata[50:19];
	assign in_ok     = 32'(in_tube) < NUM_TUBES;
	assign s_tready  = (state_q == ST_IDLE);
	assign in_xfer   = s_tvalid && s_tready;

	// temperature update
	logic        heat;
	logic [15:0] t_next;

	assign heat = energy_q > t_rd;

	always_comb begin
		if (state_q == ST_ATT_W) begin
			t_next = t_rd + prod[31:16];
		end else if (t_rd > cooling_step_q) begin
			t_next = t_rd - cooling_step_q;
		end else begin
			t_next = '0;
		end
	end

	assign twr.en   = (state_q == ST_ATT_W) || (state_q == ST_ATT && !heat);
	assign twr.idx  = TIDX_W'(tube_q);
	assign twr.data = t_next;

	// gradient side
	logic        grad_hot;
	logic [17:0] grad_q_raw;
	logic [7:0]  grad_a;

	assign grad_hot   = t_q >= T_THRESH;
	assign grad_q_raw = prod[33:16];
	always_comb begin
		if (state_q == ST_GRAD_W) begin
			grad_a = (prod[33:17] > 17'd255) ? 8'd255 : prod[24:17];
		end else begin
			grad_a = (grad_q_raw > 18'd255) ? 8'd255 : grad_q_raw[7:0];
		end
	end

	// sine lookup on the registered phase
	logic [14:0] sp;
	logic [4:0]  s_idx;
	logic [14:0] s_lo;
	logic [14:0] s_hi;
	logic [14:0] s_mag;

	always_comb begin
		if (phase_q[14]) begin
			sp = 15'(15'd16384 - {1'b0, phase_q[13:0]});
		end else begin
			sp = {1'b0, phase_q[13:0]};
		end
		s_idx = sp[14:10];
		s_lo  = qsine(s_idx);
		s_hi  = qsine(s_idx + 5'd1);
		s_mag = top_q ? 15'd32767 : 15'(lo_q + prod[24:10]);
	end

	// flicker factor and brightness
	logic [16:0] f_next;
	logic [15:0] b_val;

	assign f_next = neg_q ? (ONE_Q16 - 17'(prod[30:15])) : (ONE_Q16 + 17'(prod[30:15]));
	assign b_val  = B_BASE + prod[31:16];

	// per-row scale
	logic [17:0] v_raw;
	logic [16:0] v_sat;
	logic [24:0] v255;

	assign v_raw = prod[33:16];
	assign v_sat = (v_raw > 18'(ONE_Q16)) ? ONE_Q16 : v_raw[16:0];
	assign v255  = {v_sat, 8'd0} - 25'(v_sat);

	logic [MUL_W-1:0] k_inc;
	assign k_inc = 17'(k_q) + 17'd1;

	// operand select for the shared multiplier
	always_comb begin
		mreq = '0;
		unique case (state_q)
			ST_ATT: begin
				mreq.en = heat;
				mreq.a  = 17'(energy_q - t_rd);
				mreq.b  = 17'(attack_gain_q);
			end
			ST_GRAD: begin
				mreq.en = 1'b1;
				mreq.a  = grad_hot ? 17'(t_q - T_THRESH) : 17'(t_q);
				mreq.b  = grad_hot ? K_HOT : K_COLD;
			end
			ST_GRAD_W: begin
				mreq.en = hot_q;
				mreq.a  = prod[32:16];
				mreq.b  = K_RECIP10;
			end
			ST_PHASE: begin
				mreq.en = 1'b1;
				mreq.a  = 17'(time_lo_q);
				mreq.b  = 17'(flicker_rate_q);
			end
			ST_SINE: begin
				mreq.en = 1'b1;
				mreq.a  = 17'(s_hi - s_lo);
				mreq.b  = 17'(sp[9:0]);
			end
			ST_SINE_W: begin
				mreq.en = 1'b1;
				mreq.a  = 17'(s_mag);
				mreq.b  = 17'(flicker_depth_q);
			end
			ST_DEPTH_W: begin
				mreq.en = 1'b1;
				mreq.a  = 17'(t_q);
				mreq.b  = K_BRIGHT;
			end
			ST_BRT_W: begin
				mreq.en = 1'b1;
				mreq.a  = 17'(b_val);
				mreq.b  = f_q;
			end
			ST_ROW: begin
				mreq.en = 1'b1;
				mreq.a  = bf_q;
				mreq.b  = GLOW_TAB[row_q];
			end
			ST_CH0: begin
				mreq.en = 1'b1;
				mreq.a  = 17'(rgb_q[0]);
				mreq.b  = k_inc;
			end
			ST_CH1: begin
				mreq.en = 1'b1;
				mreq.a  = 17'(rgb_q[1]);
				mreq.b  = k_inc;
			end
			ST_CH2: begin
				mreq.en = 1'b1;
				mreq.a  = 17'(rgb_q[2]);
				mreq.b  = k_inc;
			end
			default: begin
				mreq = '0;
			end
		endcase
	end

	fgcr_mul u_mul (
		.clk  (clk),
		.req  (mreq),
		.prod (prod)
	);

	fgcr_tstore u_tstore (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (twr),
		.rd_idx  (TIDX_W'(tube_q)),
		.rd_data (t_rd)
	);

	logic out_free;
	assign out_free = !m_tvalid || m_tready;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			attack_gain_q   <= 16'd2621;
			cooling_step_q  <= 16'd262;
			flicker_rate_q  <= 8'd23;
			flicker_depth_q <= 16'd2621;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_ATTACK_GAIN:   attack_gain_q   <= cfg_data;
				CFG_COOLING_STEP:  cooling_step_q  <= cfg_data;
				CFG_FLICKER_RATE:  flicker_rate_q  <= cfg_data[7:0];
				CFG_FLICKER_DEPTH: flicker_depth_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// sequencer, working registers and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			m_tvalid <= 1'b0;
		end else begin
			// a taken pixel leaves unless the next one is loaded in its place
			if (m_tready && !(state_q == ST_EMIT && out_free)) begin
				m_tvalid <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_xfer) begin
						tube_q    <= in_tube;
						energy_q  <= in_energy;
						time_lo_q <= in_time[15:0];
						// out-of-range tube: dropped, no pixels
						if (in_ok) begin
							state_q <= ST_ATT;
						end
					end
				end
				ST_ATT: begin
					if (heat) begin
						state_q <= ST_ATT_W;
					end else begin
						t_q     <= t_next;
						state_q <= ST_GRAD;
					end
				end
				ST_ATT_W: begin
					t_q     <= t_next;
					state_q <= ST_GRAD;
				end
				ST_GRAD: begin
					hot_q   <= grad_hot;
					state_q <= ST_GRAD_W;
				end
				ST_GRAD_W: begin
					// hot segment still needs the divide by ten
					if (hot_q) begin
						state_q <= ST_DIV_W;
					end else begin
						a_q     <= grad_a;
						state_q <= ST_PHASE;
					end
				end
				ST_DIV_W: begin
					a_q     <= grad_a;
					state_q <= ST_PHASE;
				end
				ST_PHASE: begin
					if (hot_q) begin
						rgb_q[0] <= mix_ch(WARM_R, HOT_R, a_q);
						rgb_q[1] <= mix_ch(WARM_G, HOT_G, a_q);
						rgb_q[2] <= mix_ch(WARM_B, HOT_B, a_q);
					end else begin
						rgb_q[0] <= mix_ch(COLD_R, WARM_R, a_q);
						rgb_q[1] <= mix_ch(COLD_G, WARM_G, a_q);
						rgb_q[2] <= mix_ch(COLD_B, WARM_B, a_q);
					end
					state_q <= ST_PHASE_W;
				end
				ST_PHASE_W: begin
					phase_q <= prod[15:0] + 16'({13'd0, tube_q} * TUBE_PHASE);
					state_q <= ST_SINE;
				end
				ST_SINE: begin
					lo_q    <= s_lo;
					top_q   <= s_idx[4];
					neg_q   <= phase_q[15];
					state_q <= ST_SINE_W;
				end
				ST_SINE_W: begin
					state_q <= ST_DEPTH_W;
				end
				ST_DEPTH_W: begin
					f_q     <= f_next;
					state_q <= ST_BRT_W;
				end
				ST_BRT_W: begin
					state_q <= ST_BF_W;
				end
				ST_BF_W: begin
					bf_q    <= prod[32:16];
					row_q   <= '0;
					state_q <= ST_ROW;
				end
				ST_ROW: begin
					state_q <= ST_ROW_K;
				end
				ST_ROW_K: begin
					k_q     <= v255[23:16];
					state_q <= ST_CH0;
				end
				ST_CH0: begin
					state_q <= ST_CH1;
				end
				ST_CH1: begin
					red_q   <= prod[15:8];
					state_q <= ST_CH2;
				end
				ST_CH2: begin
					green_q <= prod[15:8];
					state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					// blue is still held in the product register
					if (out_free) begin
						m_tvalid <= 1'b1;
						m_tdata  <= {1'b0, prod[15:8], green_q, red_q,
							ROW_W'(row_q), tube_q};
						m_tlast  <= (row_q == LAST_ROW);
						if (row_q == LAST_ROW) begin
							state_q <= ST_IDLE;
						end else begin
							row_q   <= row_q + 1'b1;
							state_q <= ST_ROW;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	`FGCR_ASSERT_IMP(a_last_row, clk, arst_n, m_tvalid && m_tlast, m_tdata[6:3] == ROW_W'(NUM_ROWS - 1), "tlast on a row other than the final one")
	`FGCR_ASSERT_NXT(a_item_start, clk, arst_n, in_xfer && in_ok, state_q == ST_ATT, "accepted item did not start the temperature update")
	`FGCR_ASSERT_IMP(a_temp_write, clk, arst_n, twr.en, state_q == ST_ATT || state_q == ST_ATT_W, "temperature written outside the update step")
	`FGCR_ASSERT_IMP(a_row_scale, clk, arst_n, state_q == ST_ROW_K, $past(state_q) == ST_ROW && $past(mreq.en), "row scale taken without a glow product")

endmodule
`default_nettype wire

// ----- tb/sv/tb_filament_glow_column_renderer_core.sv -----
// self-checking testbench of the filament glow column renderer core
`timescale 1ns / 1ps
module tb_filament_glow_column_renderer_core;
	import fgcr_pkg::*;

	localparam int LIMIT_CYCLES  = 1000000;
	// the core is idle once its last pixel transfers, the margin covers the checker
	localparam int SETTLE_CYCLES = 16;
	localparam int DRAIN_LIMIT   = 200000;
	localparam int IDLE_PCT      = 25;
	localparam int TUBE_PHASE    = 7301;
	localparam int T_SPLIT       = 26214;

	// one rendered pixel, the fields of the pixel stream
	typedef struct {
		logic [TUBE_W-1:0] column;
		logic [ROW_W-1:0]  row;
		logic [CH_W-1:0]   red;
		logic [CH_W-1:0]   green;
		logic [CH_W-1:0]   blue;
		logic              last;
	} glow_pixel_t;

	// filament model: tube temperatures, register mirror and the pixels due
	class glow_scoreboard;
		int unsigned heat[NUM_TUBES];
		int unsigned gain;
		int unsigned cool;
		int unsigned rate;
		int unsigned depth;
		glow_pixel_t pending_pixels[$];
		int errors;
		int columns_seen;
		int pixels_checked;
		int unsigned sine_pts[17] = '{0, 3212, 6393, 9512, 12539, 15446, 18204, 20787,
			23170, 25329, 27245, 28898, 30273, 31356, 32137, 32609, 32767};
		int unsigned cold[3] = '{30, 0, 0};
		int unsigned warm[3] = '{255, 80, 0};
		int unsigned hot[3]  = '{255, 255, 255};

		function new();
			foreach (heat[i]) begin
				heat[i] = 0;
			end
			gain  = 2621;
			cool  = 262;
			rate  = 23;
			depth = 2621;
			errors = 0;
			columns_seen = 0;
			pixels_checked = 0;
		endfunction

		function void set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
			case (idx)
				CFG_ATTACK_GAIN:   gain  = 32'(val);
				CFG_COOLING_STEP:  cool  = 32'(val);
				CFG_FLICKER_RATE:  rate  = 32'(val[7:0]);
				CFG_FLICKER_DEPTH: depth = 32'(val);
				default: ;
			endcase
		endfunction

		function int unsigned blend(input int unsigned x, input int unsigned y, input int unsigned a);
			if (a == 0) begin
				return x;
			end
			if (a == 255) begin
				return y;
			end
			return ((x * 256 + y + y * a - x * a) >> 8) & 255;
		endfunction

		function int pending();
			return pending_pixels.size();
		endfunction

		// update the tube temperature and queue the pixels of its column
		function void render_column(input logic [TUBE_W-1:0] tube, input logic [ENERGY_W-1:0] energy,
				input logic [TIME_W-1:0] tms);
			int unsigned t, a, phase, quad, p, idx, frac, s, mag, f, b, ad, g, k;
			longint unsigned wide, bf, v;
			bit neg;
			int unsigned rgb[3];
			glow_pixel_t px;
			columns_seen++;
			t = heat[tube];
			if (energy > t) begin
				wide = longint'(energy - t) * longint'(gain);
				t = t + int'(wide >> 16);
			end else begin
				t = (t > cool) ? t - cool : 0;
			end
			if (t > 65535) begin
				t = 65535;
			end
			heat[tube] = t;

			// two-segment gradient, cold to warm below the split, warm to hot above
			if (t < T_SPLIT) begin
				a = (t * 1275) >> 17;
				if (a > 255) begin
					a = 255;
				end
				for (int c = 0; c < 3; c++) begin
					rgb[c] = blend(cold[c], warm[c], a);
				end
			end else begin
				wide = longint'(t - T_SPLIT) * 4233;
				a = int'(wide / 655360);
				if (a > 255) begin
					a = 255;
				end
				for (int c = 0; c < 3; c++) begin
					rgb[c] = blend(warm[c], hot[c], a);
				end
			end

			// flicker from the quarter-wave table, mirrored per quadrant
			phase = (tms * rate + tube * TUBE_PHASE) & 32'hFFFF;
			quad = (phase >> 14) & 3;
			p = phase & 32'h3FFF;
			if (quad & 1) begin
				p = 32'h4000 - p;
			end
			idx = p >> 10;
			frac = p & 1023;
			neg = (quad >= 2);
			if (idx >= 16) begin
				s = sine_pts[16];
			end else begin
				s = sine_pts[idx] + (((sine_pts[idx + 1] - sine_pts[idx]) * frac) >> 10);
			end
			wide = longint'(s) * longint'(depth);
			mag = int'(wide >> 15);
			f = neg ? 65536 - mag : 65536 + mag;

			wide = longint'(t) * 55706;
			b = 9830 + int'(wide >> 16);
			bf = (longint'(b) * longint'(f)) >> 16;

			for (int y = 0; y < NUM_ROWS; y++) begin
				ad = (2 * y >= NUM_ROWS) ? 2 * y - NUM_ROWS : NUM_ROWS - 2 * y;
				g = 65536 - (45875 * ad) / NUM_ROWS;
				v = (bf * longint'(g)) >> 16;
				if (v > 65536) begin
					v = 65536;
				end
				k = int'((v * 255) >> 16);
				px.column = tube;
				px.row    = y[ROW_W-1:0];
				px.red    = CH_W'((rgb[0] * (k + 1)) >> 8);
				px.green  = CH_W'((rgb[1] * (k + 1)) >> 8);
				px.blue   = CH_W'((rgb[2] * (k + 1)) >> 8);
				px.last   = (y == NUM_ROWS - 1);
				pending_pixels.push_back(px);
			end
		endfunction

		function void check_pixel(input logic [OUT_TDATA_W-1:0] data, input logic last_bit);
			glow_pixel_t want;
			glow_pixel_t got;
			got.column = data[2:0];
			got.row    = data[6:3];
			got.red    = data[14:7];
			got.green  = data[22:15];
			got.blue   = data[30:23];
			got.last   = last_bit;
			if (pending_pixels.size() == 0) begin
				$error("pixel with none expected: column %0d row %0d", got.column, got.row);
				errors++;
				return;
			end
			want = pending_pixels.pop_front();
			pixels_checked++;
			if (got.column !== want.column) begin
				$error("column: expected %0d actual %0d", want.column, got.column);
				errors++;
			end
			if (got.row !== want.row) begin
				$error("row: expected %0d actual %0d", want.row, got.row);
				errors++;
			end
			if (got.red !== want.red) begin
				$error("red: expected %0d actual %0d", want.red, got.red);
				errors++;
			end
			if (got.green !== want.green) begin
				$error("green: expected %0d actual %0d", want.green, got.green);
				errors++;
			end
			if (got.blue !== want.blue) begin
				$error("blue: expected %0d actual %0d", want.blue, got.blue);
				errors++;
			end
			if (got.last !== want.last) begin
				$error("last: expected %0d actual %0d", want.last, got.last);
				errors++;
			end
		endfunction
	endclass

	logic                   clk;
	logic                   arst_n;
	logic                   cfg_we;
	logic [CFG_IDX_W-1:0]   cfg_index;
	logic [CFG_DATA_W-1:0]  cfg_data;
	logic                   s_tvalid;
	logic                   s_tready;
	logic [IN_TDATA_W-1:0]  s_tdata;   // tube[2:0] energy[18:3] time_ms[50:19]
	logic                   m_tvalid;
	logic                   m_tready;
	logic [OUT_TDATA_W-1:0] m_tdata;   // column[2:0] row[6:3] red[14:7] green[22:15] blue[30:23]
	logic                   m_tlast;   // final row of the column

	glow_scoreboard sb;
	// no idling on either side while calm is set
	bit calm;
	// a positive value asks the pixel side for a hold-off of that length
	int hold_request;
	int settings_done;
	int unsigned cycle_count;

	filament_glow_column_renderer_core u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast)
	);

	initial begin
		clk = 1'b0;
		forever begin
			#4 clk = ~clk;
		end
	end

	// watchdog
	initial begin
		cycle_count = 0;
		while (cycle_count < LIMIT_CYCLES) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("status: fail");
		$finish;
	end

	// pixel side: random back-pressure plus a long hold-off on request
	initial begin
		int n;
		m_tready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_request > 0) begin
				n = hold_request;
				hold_request = 0;
				m_tready <= 1'b0;
				repeat (n) @(posedge clk);
			end else if (calm) begin
				m_tready <= 1'b1;
			end else begin
				m_tready <= ($urandom_range(0, 99) >= IDLE_PCT);
			end
		end
	end

	// every pixel transfer is checked against the oldest expected pixel
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			sb.check_pixel(m_tdata, m_tlast);
		end
	end

	// offer one item, with random gaps before it, and record it at its transfer
	task automatic send_item(input logic [TUBE_W-1:0] tube, input logic [ENERGY_W-1:0] energy,
			input logic [TIME_W-1:0] tms);
		while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= IN_TDATA_W'({tms, energy, tube});
		@(posedge clk);
		while (!s_tready) begin
			@(posedge clk);
		end
		sb.render_column(tube, energy, tms);
	endtask

	// stop offering and let every pending pixel come out
	task automatic wait_idle();
		s_tvalid <= 1'b0;
		while (sb.pending() != 0) begin
			@(posedge clk);
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// reprogram all four registers while the core is idle
	task automatic write_settings(input logic [15:0] gain_v, input logic [15:0] cool_v,
			input logic [7:0] rate_v, input logic [15:0] depth_v);
		logic [CFG_IDX_W-1:0]  idx[4];
		logic [CFG_DATA_W-1:0] val[4];
		idx = '{CFG_ATTACK_GAIN, CFG_COOLING_STEP, CFG_FLICKER_RATE, CFG_FLICKER_DEPTH};
		// junk in the unused upper byte of the rate must be ignored
		val = '{gain_v, cool_v, {8'($urandom_range(0, 255)), rate_v}, depth_v};
		wait_idle();
		for (int i = 0; i < 4; i++) begin
			cfg_we    <= 1'b1;
			cfg_index <= idx[i];
			cfg_data  <= val[i];
			@(posedge clk);
			sb.set_reg(idx[i], val[i]);
		end
		cfg_we <= 1'b0;
		settings_done++;
	endtask

	// random traffic: bursts on one tube with a running clock, plus noise
	task automatic run_phase(input int count, input bit quiet, input int hold_at,
			input int pause_at);
		logic [TUBE_W-1:0]   tube;
		logic [ENERGY_W-1:0] energy;
		logic [TIME_W-1:0]   tnow;
		int pick;
		calm = quiet;
		tube = TUBE_W'($urandom_range(0, NUM_TUBES - 1));
		tnow = $urandom;
		for (int i = 0; i < count; i++) begin
			if (i == hold_at) begin
				hold_request = 600;
			end
			if (i == pause_at) begin
				wait_idle();
			end
			if ($urandom_range(0, 99) < 40) begin
				tube = TUBE_W'($urandom_range(0, NUM_TUBES - 1));
			end
			pick = $urandom_range(0, 9);
			if (pick < 4) begin
				energy = ENERGY_W'($urandom);
			end else if (pick < 7) begin
				energy = ENERGY_W'($urandom_range(40000, 65535));
			end else if (pick < 9) begin
				energy = '0;
			end else begin
				energy = ENERGY_W'($urandom_range(0, 2000));
			end
			if ($urandom_range(0, 9) == 0) begin
				tnow = $urandom;
			end else begin
				tnow = tnow + $urandom_range(1, 40);
			end
			send_item(tube, energy, tnow);
		end
		calm = 1'b0;
	endtask

	initial begin
		int spin;
		sb = new();
		calm = 1'b0;
		hold_request = 0;
		settings_done = 0;
		arst_n    <= 1'b0;
		cfg_we    <= 1'b0;
		cfg_index <= CFG_ATTACK_GAIN;
		cfg_data  <= '0;
		s_tvalid  <= 1'b0;
		s_tdata   <= '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		repeat (4) @(posedge clk);

		// directed, reset settings: cooling at zero, full level, clock extremes
		send_item(3'd0, 16'd0, 32'd0);
		send_item(3'd7, 16'hFFFF, 32'hFFFF_FFFF);
		send_item(3'd3, 16'd40000, 32'd1000);
		send_item(3'd3, 16'd0, 32'd1001);
		send_item(3'd5, 16'hFFFF, 32'd12345);

		// directed, full gains: both sides of the gradient split, all quadrants
		write_settings(16'hFFFF, 16'hFFFF, 8'hFF, 16'hFFFF);
		send_item(3'd0, 16'd26214, 32'd0);          // just below the split
		send_item(3'd1, 16'd26215, 32'd64);         // exactly at the split
		send_item(3'd2, 16'hFFFF, 32'd65);          // nearly saturated hot
		send_item(3'd2, 16'd0, 32'd129);            // cooling clamps at zero
		send_item(3'd4, 16'd1, 32'd193);            // tiny gap rounds to no rise
		send_item(3'd6, 16'hFFFF, 32'd257);
		send_item(3'd0, 16'hFFFF, 32'd49152);       // quarter turn, top of the table
		send_item(3'd0, 16'd30000, 32'd16384);      // three-quarter turn
		send_item(3'd1, 16'hFFFF, 32'hFFFF_FFFF);
		send_item(3'd7, 16'd50000, 32'h8000_0000);

		// directed, all registers zero: temperature frozen, no flicker
		write_settings(16'd0, 16'd0, 8'd0, 16'd0);
		send_item(3'd2, 16'hFFFF, 32'd5);
		send_item(3'd6, 16'd0, 32'd6);
		send_item(3'd0, 16'hAAAA, 32'h5555_5555);

		// random phases across several settings, the extremes among them
		write_settings(16'd2621, 16'd262, 8'd23, 16'd2621);
		run_phase(70, 1'b1, -1, -1);
		write_settings(16'hFFFF, 16'hFFFF, 8'hFF, 16'hFFFF);
		run_phase(70, 1'b0, -1, -1);
		write_settings(16'($urandom), 16'($urandom_range(0, 4000)), 8'($urandom), 16'($urandom));
		run_phase(70, 1'b0, 10, -1);
		write_settings(16'd0, 16'd0, 8'd0, 16'd0);
		run_phase(70, 1'b0, -1, -1);
		write_settings(16'd20000, 16'd1000, 8'd100, 16'd30000);
		run_phase(70, 1'b0, -1, 35);
		write_settings(16'($urandom), 16'($urandom), 8'($urandom), 16'($urandom));
		run_phase(70, 1'b0, -1, -1);

		s_tvalid <= 1'b0;
		spin = 0;
		while (sb.pending() != 0 && spin < DRAIN_LIMIT) begin
			@(posedge clk);
			spin++;
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (sb.pending() != 0) begin
			$error("%0d expected pixels never arrived", sb.pending());
			sb.errors++;
		end

		$display("covered %0d column updates and %0d checked pixels over %0d register settings",
			sb.columns_seen, sb.pixels_checked, settings_done);
		$display("with long output hold-off, idle drains and random stalls on both streams");
		if (sb.errors == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule
